@@ sv/bpq_pkg.sv @@
`timescale 1ns / 1ps
package bpq_pkg;

	localparam int DEFAULT_DEPTH = 8;
	localparam int ITEM_W        = 32;
	localparam int PRIO_W        = 8;
	localparam int COUNT_OUT_W   = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic                     vld;
		logic [PRIO_W-1:0]        prio;
		logic signed [ITEM_W-1:0] item;
	} entry_t;

	typedef struct packed {
		logic   insert;
		logic   remove;
		entry_t new_ent;
	} cell_cmd_t;

endpackage

@@ sv/bpq_if.sv @@
`timescale 1ns / 1ps
interface bpq_in_if import bpq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic signed [ITEM_W-1:0] item_value;
	logic [PRIO_W-1:0]        priority_req;

	modport source(output valid, output opcode, output item_value, output priority_req,
		input ready);
	modport sink(input valid, input opcode, input item_value, input priority_req,
		output ready);
endinterface

interface bpq_out_if import bpq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [ITEM_W-1:0] removed_item;
	logic [PRIO_W-1:0]        removed_priority;
	logic [COUNT_OUT_W-1:0]   entry_count;

	modport source(output valid, output status, output removed_item,
		output removed_priority, output entry_count, input ready);
	modport sink(input valid, input status, input removed_item,
		input removed_priority, input entry_count, output ready);
endinterface

@@ sv/bpq_cell.sv @@
`timescale 1ns / 1ps
module bpq_cell import bpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  entry_t    prev_ent,
	input  logic      prev_gt,
	input  entry_t    next_ent,
	output entry_t    ent,
	output logic      gt
);

	logic                     vld_q;
	logic [PRIO_W-1:0]        prio_q;
	logic signed [ITEM_W-1:0] item_q;
	entry_t                   ent_q;
	entry_t                   ent_d;

	assign ent_q = '{vld: vld_q, prio: prio_q, item: item_q};

	// An entry of equal priority stays ahead of the new one, which keeps ties in arrival order.
	assign gt = !vld_q || (ent_q.prio > cmd.new_ent.prio);

	always_comb begin
		ent_d     = ent_q;
		ent_d.vld = vld_q;
		if (cmd.insert) begin
			if (gt && !prev_gt) begin
				ent_d = cmd.new_ent;
			end else if (gt) begin
				ent_d = prev_ent;
			end
		end else if (cmd.remove) begin
			ent_d = next_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= ent_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= ent_d.prio;
		item_q <= ent_d.item;
	end

	assign ent = ent_q;

endmodule

@@ sv/bounded_priority_queue_core.sv @@
`timescale 1ns / 1ps
// Fixed-capacity minimum priority queue built as a sorted row of cells.
// The cmd channel carries one transaction per operation: opcode 0 inserts
// item_value with priority_req, opcode 1 removes the entry of smallest
// priority, the earliest inserted among equals. The rsp channel returns one
// transaction per operation with its status, the removed entry (zero when
// nothing is removed) and the number of entries held afterwards.
// Every operation completes in the cycle it is accepted: all cells compare
// their priority with the new one and shift left or right by one place in
// that same clock, and the result is registered in the rsp stage. Throughput is
// one transaction per cycle while rsp is taken. When the receiver stalls, the
// registered result waits and cmd ready falls until it is taken; nothing is
// lost. Reset empties the queue at once by clearing the valid bit of every
// cell.
module bounded_priority_queue_core import bpq_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	bpq_in_if.sink    cmd,
	bpq_out_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t    ent     [DEPTH];
	logic      gt      [DEPTH];
	entry_t    prev_ent[DEPTH];
	logic      prev_gt [DEPTH];
	entry_t    next_ent[DEPTH];
	logic [DEPTH-1:0] vld_vec;
	cell_cmd_t cell_cmd;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             accept;
	logic             full;
	logic             empty;
	logic             is_remove;

	logic                     rsp_valid_q;
	status_t                  rsp_status_q;
	logic signed [ITEM_W-1:0] rsp_item_q;
	logic [PRIO_W-1:0]        rsp_prio_q;
	logic [COUNT_OUT_W-1:0]   rsp_count_q;
	status_t                  status_d;
	logic signed [ITEM_W-1:0] item_d;
	logic [PRIO_W-1:0]        prio_d;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign is_remove = (cmd.opcode == OP_REMOVE);

	always_comb begin
		cell_cmd.insert       = accept && !is_remove && !full;
		cell_cmd.remove       = accept && is_remove && !empty;
		cell_cmd.new_ent.vld  = 1'b1;
		cell_cmd.new_ent.prio = cmd.priority_req;
		cell_cmd.new_ent.item = cmd.item_value;
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign prev_ent[i] = cell_cmd.new_ent;
				assign prev_gt[i]  = 1'b0;
			end else begin : g_mid
				assign prev_ent[i] = ent[i-1];
				assign prev_gt[i]  = gt[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign next_ent[i] = '0;
			end else begin : g_next
				assign next_ent[i] = ent[i+1];
			end
			assign vld_vec[i] = ent[i].vld;

			bpq_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cell_cmd),
				.prev_ent (prev_ent[i]),
				.prev_gt  (prev_gt[i]),
				.next_ent (next_ent[i]),
				.ent      (ent[i]),
				.gt       (gt[i])
			);
		end
	endgenerate

	always_comb begin
		count_d  = count_q;
		status_d = ST_INSERTED;
		item_d   = '0;
		prio_d   = '0;
		if (is_remove) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				status_d = ST_REMOVED;
				item_d   = ent[0].item;
				prio_d   = ent[0].prio;
				count_d  = count_q - CNT_W'(1);
			end
		end else begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_status_q <= status_d;
			rsp_item_q   <= item_d;
			rsp_prio_q   <= prio_d;
			rsp_count_q  <= COUNT_OUT_W'(count_d);
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.removed_item     = rsp_item_q;
	assign rsp.removed_priority = rsp_prio_q;
	assign rsp.entry_count      = rsp_count_q;

`ifndef SYNTHESIS
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_remove && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted insert did not add an entry");

	a_remove_takes_head: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_remove && !empty) |=>
		(rsp_prio_q == $past(ent[0].prio) && rsp_status_q == ST_REMOVED))
		else $error("removal did not return the head entry");
`endif

endmodule

@@ test/tb_bounded_priority_queue_core.sv @@
`timescale 1ns / 1ps
module tb_bounded_priority_queue_core;
	import bpq_pkg::*;

	localparam int DEPTH       = DEFAULT_DEPTH;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [PRIO_W-1:0]        prio;
		logic signed [ITEM_W-1:0] item;
	} held_entry_t;

	typedef struct {
		status_t                  status;
		logic signed [ITEM_W-1:0] item;
		logic [PRIO_W-1:0]        prio;
		logic [COUNT_OUT_W-1:0]   count;
	} outcome_t;

	logic clk;
	logic arst_n;

	bpq_in_if  cmd_if ();
	bpq_out_if rsp_if ();

	bounded_priority_queue_core #(.DEPTH(DEPTH)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.rsp   (rsp_if)
	);

	held_entry_t model_entries[$];
	outcome_t    predicted_outcomes[$];
	outcome_t    oldest_outcome;
	int          error_count;
	int          status_seen[4];
	bit          idle_en;
	bit          stall_en;
	int          hold_request;
	int          cycle_count;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic outcome_t apply_queue_op(input opcode_t op,
		input logic signed [ITEM_W-1:0] val, input logic [PRIO_W-1:0] pr);
		outcome_t o;
		int       best;
		o.item = '0;
		o.prio = '0;
		if (op == OP_INSERT) begin
			if (model_entries.size() >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				model_entries.push_back('{prio: pr, item: val});
				o.status = ST_INSERTED;
			end
		end else if (model_entries.size() == 0) begin
			o.status = ST_EMPTY;
		end else begin
			// The oldest entry wins a tie because only a strictly smaller priority replaces it.
			best = 0;
			for (int k = 1; k < model_entries.size(); k++) begin
				if (model_entries[k].prio < model_entries[best].prio) begin
					best = k;
				end
			end
			o.item = model_entries[best].item;
			o.prio = model_entries[best].prio;
			model_entries.delete(best);
			o.status = ST_REMOVED;
		end
		o.count = COUNT_OUT_W'(model_entries.size());
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [ITEM_W-1:0] want,
		input logic [ITEM_W-1:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	task automatic send_op(input opcode_t op, input logic signed [ITEM_W-1:0] val,
		input logic [PRIO_W-1:0] pr);
		while (idle_en && $urandom_range(0, 99) < 11) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid        <= 1'b1;
		cmd_if.opcode       <= op;
		cmd_if.item_value   <= val;
		cmd_if.priority_req <= pr;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		predicted_outcomes.push_back(apply_queue_op(op, val, pr));
	endtask

	task automatic send_random(input int insert_pct);
		opcode_t           op;
		logic [PRIO_W-1:0] pr;
		op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
		pr = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom_range(0, 255));
		send_op(op, $urandom(), pr);
	endtask

	task automatic test_directed_extremes();
		send_op(OP_REMOVE, 32'sh7FFFFFFF, 8'hFF);
		send_op(OP_INSERT, 32'sh7FFFFFFF, 8'hFF);
		send_op(OP_INSERT, 32'sh80000000, 8'h00);
		send_op(OP_INSERT, 32'sh00000000, 8'h80);
		send_op(OP_INSERT, -32'sd1, 8'h00);
		send_op(OP_INSERT, 32'sh00000001, 8'hFF);
		send_op(OP_INSERT, 32'sh55555555, 8'hAA);
		send_op(OP_INSERT, 32'shAAAAAAAA, 8'h55);
		send_op(OP_INSERT, 32'sh00000002, 8'h00);
		send_op(OP_INSERT, 32'sh12345678, 8'h01);
		repeat (DEPTH) send_op(OP_REMOVE, $urandom(), PRIO_W'($urandom_range(0, 255)));
		send_op(OP_REMOVE, 32'sh80000000, 8'h00);
	endtask

	task automatic test_receiver_hold_off();
		idle_en      = 1'b0;
		stall_en     = 1'b0;
		hold_request = 120;
		repeat (40) send_random(70);
		idle_en  = 1'b1;
		stall_en = 1'b1;
	endtask

	task automatic test_random_mix();
		int insert_pct;
		for (int chunk = 0; chunk < 18; chunk++) begin
			case ($urandom_range(0, 2))
				0: begin
					insert_pct = 15;
				end
				1: begin
					insert_pct = 50;
				end
				default: begin
					insert_pct = 85;
				end
			endcase
			idle_en  = (chunk != 5);
			stall_en = (chunk != 5);
			repeat (100) send_random(insert_pct);
		end
		idle_en  = 1'b1;
		stall_en = 1'b1;
	endtask

	task automatic test_drain_and_report();
		cmd_if.valid <= 1'b0;
		while (predicted_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("Checked %0d inserts, %0d removals, %0d refused when full, %0d refused when empty.",
			status_seen[ST_INSERTED], status_seen[ST_REMOVED], status_seen[ST_FULL],
			status_seen[ST_EMPTY]);
		$display("Stimulus: directed extremes and ties, a long receiver hold-off, random mixes.");
		if (error_count == 0) begin
			$display("[bounded_priority_queue_core] OK");
		end else begin
			$display("[bounded_priority_queue_core] ERROR");
		end
	endtask

	initial begin : rsp_receiver
		int hold_left;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (stall_en) begin
				rsp_if.ready <= ($urandom_range(0, 99) >= 11);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (predicted_outcomes.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected transaction, expected none, actual status %0d",
					$time, rsp_if.status);
			end else begin
				oldest_outcome = predicted_outcomes.pop_front();
				status_seen[oldest_outcome.status]++;
				check_field("status", oldest_outcome.status, rsp_if.status);
				check_field("removed_item", oldest_outcome.item, rsp_if.removed_item);
				check_field("removed_priority", oldest_outcome.prio, rsp_if.removed_priority);
				check_field("entry_count", oldest_outcome.count, rsp_if.entry_count);
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t ns: timeout after %0d cycles", $time, cycle_count);
		$display("[bounded_priority_queue_core] ERROR");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		idle_en      = 1'b1;
		stall_en     = 1'b1;
		hold_request = 0;
		error_count  = 0;
		cmd_if.valid        <= 1'b0;
		cmd_if.opcode       <= OP_INSERT;
		cmd_if.item_value   <= '0;
		cmd_if.priority_req <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_receiver_hold_off();
		test_random_mix();
		test_drain_and_report();
		$finish;
	end

endmodule

@@ filelist.f @@
sv/bpq_pkg.sv
sv/bpq_if.sv
sv/bpq_cell.sv
sv/bounded_priority_queue_core.sv
test/tb_bounded_priority_queue_core.sv
